[src/rcbe_pkg.sv]
// ----------------------------------------------------------------------------
// rcbe_pkg: shared constants and types of the 3x3 rgb blur / edge filter
// line store geometry, register codes, pipeline tags and output item layout
// ----------------------------------------------------------------------------
package rcbe_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int EW_W       = COL_W + 1;
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 13;
  localparam int OROW_W     = 12;

  localparam int CH_W   = 8;
  localparam int NUM_CH = 3;
  localparam int PIX_W  = NUM_CH * CH_W;
  localparam int LINE_W = 2 * PIX_W;
  localparam int CSUM_W = 10;
  localparam int SUM_W  = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_ROW     = 3'd4;

  localparam logic MODE_BLUR    = 1'b0;
  localparam logic MODE_LAPLACE = 1'b1;

  localparam logic [SUM_W-1:0] RECIP_NINE = 12'd3641;
  localparam int               RECIP_SHIFT = 15;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef struct packed {
    logic             valid;
    logic             wr;
    logic             emit;
    logic             filt;
    logic             last;
    logic             mode;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] bot;
  } issue_t;

  typedef struct packed {
    logic e1;
    logic e2;
    logic e3;
  } pipe_busy_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
  } out_item_t;

endpackage

[src/rcbe_line_ram.sv]
// ----------------------------------------------------------------------------
// rcbe_line_ram: the two line stores side by side in one memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module rcbe_line_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [rcbe_pkg::COL_W-1:0]  wr_addr,
  input  logic [rcbe_pkg::LINE_W-1:0] wr_data,
  input  logic [rcbe_pkg::COL_W-1:0]  rd_addr,
  output logic [rcbe_pkg::LINE_W-1:0] rd_data
);

  logic [rcbe_pkg::LINE_W-1:0] mem [rcbe_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/rcbe_ctrl.sv]
// ----------------------------------------------------------------------------
// rcbe_ctrl: registers, raster counters and item admission
// decides per item whether it counts, whether it yields a result and how
// ----------------------------------------------------------------------------
module rcbe_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [rcbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcbe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           action,
  input  logic [rcbe_pkg::CH_W-1:0]       pixel_red,
  input  logic [rcbe_pkg::CH_W-1:0]       pixel_green,
  input  logic [rcbe_pkg::CH_W-1:0]       pixel_blue,
  input  rcbe_pkg::pipe_busy_t            busy,
  input  logic [rcbe_pkg::FIFO_CW-1:0]    fifo_count,
  output rcbe_pkg::issue_t                issue
);

  localparam int EW_W   = rcbe_pkg::EW_W;
  localparam int ROW_W  = rcbe_pkg::ROW_W;
  localparam int COL_W  = rcbe_pkg::COL_W;
  localparam int OROW_W = rcbe_pkg::OROW_W;
  localparam int PEND_W = rcbe_pkg::FIFO_CW + 1;

  logic              cfg_mode;
  logic [11:0]       cfg_width;
  logic [12:0]       cfg_height;
  logic [12:0]       cfg_first;
  logic [12:0]       cfg_stop;

  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  out_col;
  logic [OROW_W-1:0] out_row;

  logic [EW_W-1:0]   eff_w;
  logic [ROW_W-1:0]  eff_h;
  logic [PEND_W-1:0] pending;
  logic [ROW_W-1:0]  r_plus;
  logic              draining;
  logic              take;
  logic              emit;
  logic              in_col_wrap;
  logic              out_col_wrap;
  logic              border;
  logic              filt;
  logic              last;
  logic              restart;

  always_comb begin
    priority if (cfg_width == '0) begin
      eff_w = EW_W'(1);
    end else if (32'(cfg_width) > rcbe_pkg::MAX_WIDTH) begin
      eff_w = EW_W'(rcbe_pkg::MAX_WIDTH);
    end else begin
      eff_w = EW_W'(cfg_width);
    end
    priority if (cfg_height == '0) begin
      eff_h = ROW_W'(1);
    end else if (32'(cfg_height) > rcbe_pkg::MAX_HEIGHT) begin
      eff_h = ROW_W'(rcbe_pkg::MAX_HEIGHT);
    end else begin
      eff_h = cfg_height;
    end
  end

  // results already queued or on their way must fit the output queue
  assign pending = PEND_W'(fifo_count) + PEND_W'(busy.e1) + PEND_W'(busy.e2)
                 + PEND_W'(busy.e3);
  assign in_stall = pending >= PEND_W'(rcbe_pkg::FIFO_DEPTH);

  assign draining     = in_row >= eff_h;
  assign take         = in_valid && !in_stall && (action == draining);
  assign emit         = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_col != '0));
  assign in_col_wrap  = (EW_W'(in_col) + EW_W'(1)) >= eff_w;
  assign out_col_wrap = (EW_W'(out_col) + EW_W'(1)) >= eff_w;
  assign r_plus       = ROW_W'(out_row) + ROW_W'(1);
  assign border       = (out_row == '0) || (r_plus >= eff_h) || (out_col == '0) || out_col_wrap;
  assign filt         = !border && (ROW_W'(out_row) >= cfg_first)
                      && (ROW_W'(out_row) < cfg_stop);
  assign last         = (r_plus == eff_h) && ((EW_W'(out_col) + EW_W'(1)) == eff_w);
  assign restart      = cfg_write && ((cfg_index == rcbe_pkg::REG_IMAGE_WIDTH)
                      || (cfg_index == rcbe_pkg::REG_IMAGE_HEIGHT));

  always_comb begin
    issue.valid = take;
    issue.wr    = !action;
    issue.emit  = emit;
    issue.filt  = filt;
    issue.last  = last;
    issue.mode  = cfg_mode;
    issue.addr  = in_col;
    issue.bot   = action ? '0 : {pixel_red, pixel_green, pixel_blue};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode   <= rcbe_pkg::MODE_BLUR;
      cfg_width  <= 12'd2048;
      cfg_height <= 13'd4096;
      cfg_first  <= '0;
      cfg_stop   <= 13'd4096;
      in_col     <= '0;
      in_row     <= '0;
      out_col    <= '0;
      out_row    <= '0;
    end else begin
      if (restart) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else if (take) begin
        if (emit && last) begin
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end else begin
          if (in_col_wrap) begin
            in_col <= '0;
            in_row <= in_row + ROW_W'(1);
          end else begin
            in_col <= in_col + COL_W'(1);
          end
          if (emit) begin
            if (out_col_wrap) begin
              out_col <= '0;
              out_row <= out_row + OROW_W'(1);
            end else begin
              out_col <= out_col + COL_W'(1);
            end
          end
        end
      end
      if (cfg_write) begin
        unique case (cfg_index)
          rcbe_pkg::REG_FILTER_MODE: begin
            cfg_mode <= cfg_data[0];
          end
          rcbe_pkg::REG_IMAGE_WIDTH: begin
            cfg_width <= cfg_data[11:0];
          end
          rcbe_pkg::REG_IMAGE_HEIGHT: begin
            cfg_height <= cfg_data;
          end
          rcbe_pkg::REG_FIRST_ROW: begin
            cfg_first <= cfg_data;
          end
          rcbe_pkg::REG_STOP_ROW: begin
            cfg_stop <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_in_col_range: assert property (@(posedge clk) disable iff (rst)
    EW_W'(in_col) < eff_w)
    else $error("input column beyond row width");

  a_out_row_range: assert property (@(posedge clk) disable iff (rst)
    ROW_W'(out_row) < eff_h)
    else $error("output row beyond image height");

endmodule

[src/rcbe_datapath.sv]
// ----------------------------------------------------------------------------
// rcbe_datapath: line store read-modify-write and the 3x3 arithmetic
// window of column sums, box sum or laplacian, divide by nine
// ----------------------------------------------------------------------------
module rcbe_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  rcbe_pkg::issue_t             issue,
  input  logic [rcbe_pkg::LINE_W-1:0]  rd_data,
  output logic                        ram_we,
  output logic [rcbe_pkg::COL_W-1:0]   ram_waddr,
  output logic [rcbe_pkg::LINE_W-1:0]  ram_wdata,
  output rcbe_pkg::pipe_busy_t         busy,
  output logic                        push,
  output rcbe_pkg::out_item_t          push_item
);

  localparam int CH_W   = rcbe_pkg::CH_W;
  localparam int NUM_CH = rcbe_pkg::NUM_CH;
  localparam int PIX_W  = rcbe_pkg::PIX_W;
  localparam int LINE_W = rcbe_pkg::LINE_W;
  localparam int CSUM_W = rcbe_pkg::CSUM_W;
  localparam int SUM_W  = rcbe_pkg::SUM_W;
  localparam int PROD_W = 2 * SUM_W;

  rcbe_pkg::issue_t  s1;
  logic              fwd;
  logic [LINE_W-1:0] fwd_data;

  logic [PIX_W-1:0]  win_mid;
  logic [CSUM_W-1:0] cs_a [NUM_CH];
  logic [CSUM_W-1:0] cs_b [NUM_CH];

  logic              e2;
  logic              f2;
  logic              l2;
  logic              m2;
  logic [PIX_W-1:0]  centre2;
  logic [SUM_W-1:0]  total2 [NUM_CH];

  logic              e3;
  logic              f3;
  logic              l3;
  logic [PIX_W-1:0]  centre3;
  logic [SUM_W-1:0]  op3 [NUM_CH];

  logic [LINE_W-1:0] line;
  logic [PIX_W-1:0]  top;
  logic [PIX_W-1:0]  mid;
  logic [CSUM_W-1:0] newsum [NUM_CH];
  logic [SUM_W-1:0]  total [NUM_CH];
  logic [SUM_W-1:0]  c9 [NUM_CH];
  logic [SUM_W:0]    diff [NUM_CH];
  logic [SUM_W-1:0]  op [NUM_CH];
  logic [PROD_W-1:0] prod [NUM_CH];
  logic [CH_W-1:0]   chv [NUM_CH];

  // stage 1: line data, forwarded when the previous item wrote the same entry
  always_comb begin
    line      = fwd ? fwd_data : rd_data;
    top       = line[LINE_W-1:PIX_W];
    mid       = line[PIX_W-1:0];
    ram_we    = s1.valid && s1.wr;
    ram_waddr = s1.addr;
    ram_wdata = {mid, s1.bot};
    for (int ch = 0; ch < NUM_CH; ch++) begin
      newsum[ch] = CSUM_W'(top[ch*CH_W +: CH_W]) + CSUM_W'(mid[ch*CH_W +: CH_W])
                 + CSUM_W'(s1.bot[ch*CH_W +: CH_W]);
      total[ch]  = SUM_W'(cs_a[ch]) + SUM_W'(cs_b[ch]) + SUM_W'(newsum[ch]);
    end
  end

  // stage 2: dividend, laplacian clamped at zero
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      c9[ch]   = (SUM_W'(centre2[ch*CH_W +: CH_W]) << 3) + SUM_W'(centre2[ch*CH_W +: CH_W]);
      diff[ch] = {1'b0, c9[ch]} - {1'b0, total2[ch]};
      if (m2 == rcbe_pkg::MODE_BLUR) begin
        op[ch] = total2[ch];
      end else begin
        op[ch] = diff[ch][SUM_W] ? '0 : diff[ch][SUM_W-1:0];
      end
    end
  end

  // stage 3: divide by nine through the reciprocal, or pass the centre if unfiltered
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch] = PROD_W'(op3[ch]) * PROD_W'(rcbe_pkg::RECIP_NINE);
      chv[ch]  = f3 ? prod[ch][rcbe_pkg::RECIP_SHIFT +: CH_W] : centre3[ch*CH_W +: CH_W];
    end
    push                = e3;
    push_item.red       = chv[2];
    push_item.green     = chv[1];
    push_item.blue      = chv[0];
    push_item.frame_end = l3;
  end

  assign busy.e1 = s1.valid && s1.emit;
  assign busy.e2 = e2;
  assign busy.e3 = e3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1      <= '0;
      fwd     <= 1'b0;
      win_mid <= '0;
      e2      <= 1'b0;
      e3      <= 1'b0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        cs_a[ch] <= '0;
        cs_b[ch] <= '0;
      end
    end else begin
      s1  <= issue;
      fwd <= issue.valid && s1.valid && s1.wr && (issue.addr == s1.addr);
      if (s1.valid) begin
        win_mid <= mid;
        for (int ch = 0; ch < NUM_CH; ch++) begin
          cs_b[ch] <= cs_a[ch];
          cs_a[ch] <= newsum[ch];
        end
      end
      e2 <= s1.valid && s1.emit;
      e3 <= e2;
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= ram_wdata;
    f2       <= s1.filt;
    l2       <= s1.last;
    m2       <= s1.mode;
    centre2  <= win_mid;
    f3       <= f2;
    l3       <= l2;
    centre3  <= centre2;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      total2[ch] <= total[ch];
      op3[ch]    <= op[ch];
    end
  end

  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    fwd |-> s1.valid && $past(s1.valid && s1.wr) && (s1.addr == $past(s1.addr)))
    else $error("forwarding without a matching write");

endmodule

[src/rcbe_out_fifo.sv]
// ----------------------------------------------------------------------------
// rcbe_out_fifo: small result queue in front of the output channel
// decouples the pipeline from output stalls
// ----------------------------------------------------------------------------
module rcbe_out_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  rcbe_pkg::out_item_t          push_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rcbe_pkg::out_item_t          head,
  output logic [rcbe_pkg::FIFO_CW-1:0] count
);

  localparam int AW = rcbe_pkg::FIFO_AW;
  localparam int CW = rcbe_pkg::FIFO_CW;

  rcbe_pkg::out_item_t store [rcbe_pkg::FIFO_DEPTH];
  logic [AW-1:0]       wr_ptr;
  logic [AW-1:0]       rd_ptr;
  logic                pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && !out_stall;
  assign head      = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != CW'(rcbe_pkg::FIFO_DEPTH))
    else $error("result pushed into a full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(rcbe_pkg::FIFO_DEPTH))
    else $error("queue count out of range");

endmodule

[src/rgb_conv3x3_blur_edge_top.sv]
// ----------------------------------------------------------------------------
// rgb_conv3x3_blur_edge_top: streaming 3x3 rgb box blur / laplacian filter
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_write             cfg_index, cfg_data
//   in       in         in_valid / in_stall   action, pixel_red/green/blue
//   out      out        out_valid / out_stall out_red/green/blue, frame_end
//
// one item per clock while in_stall is low; the line store is read once per item
// and written only for pixel items; a result passes registers s1, e2 and e3
// before it enters the output queue; in_stall rises only when queued and
// in-flight results would fill the eight-entry output queue
// rst is synchronous; the line store needs no clearing pass after reset
// ----------------------------------------------------------------------------
module rgb_conv3x3_blur_edge_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [rcbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcbe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           action,
  input  logic [rcbe_pkg::CH_W-1:0]       pixel_red,
  input  logic [rcbe_pkg::CH_W-1:0]       pixel_green,
  input  logic [rcbe_pkg::CH_W-1:0]       pixel_blue,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rcbe_pkg::CH_W-1:0]       out_red,
  output logic [rcbe_pkg::CH_W-1:0]       out_green,
  output logic [rcbe_pkg::CH_W-1:0]       out_blue,
  output logic                           frame_end
);

  rcbe_pkg::issue_t                issue;
  rcbe_pkg::pipe_busy_t            busy;
  rcbe_pkg::out_item_t             push_item;
  rcbe_pkg::out_item_t             head;
  logic [rcbe_pkg::FIFO_CW-1:0]    fifo_count;
  logic                           push;
  logic                           ram_we;
  logic [rcbe_pkg::COL_W-1:0]      ram_waddr;
  logic [rcbe_pkg::LINE_W-1:0]     ram_wdata;
  logic [rcbe_pkg::LINE_W-1:0]     rd_data;

  rcbe_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .pixel_red  (pixel_red),
    .pixel_green(pixel_green),
    .pixel_blue (pixel_blue),
    .busy       (busy),
    .fifo_count (fifo_count),
    .issue      (issue)
  );

  rcbe_line_ram u_line_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(issue.addr),
    .rd_data(rd_data)
  );

  rcbe_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .rd_data  (rd_data),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .busy     (busy),
    .push     (push),
    .push_item(push_item)
  );

  rcbe_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head     (head),
    .count    (fifo_count)
  );

  assign out_red   = head.red;
  assign out_green = head.green;
  assign out_blue  = head.blue;
  assign frame_end = head.frame_end;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: 3x3 rgb box blur / laplacian filter
// directed frames with extreme pixels, then random frames under random
// register settings; every result is scored against a line-store model of
// the filter, with random idling on both sides and long output hold-offs
// ----------------------------------------------------------------------------
module testbench;

  localparam int CH_W       = rcbe_pkg::CH_W;
  localparam int PIX_W      = rcbe_pkg::PIX_W;
  localparam int NUM_CH     = rcbe_pkg::NUM_CH;
  localparam int MAX_WIDTH  = rcbe_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT = rcbe_pkg::MAX_HEIGHT;
  localparam int CFG_IDX_W  = rcbe_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = rcbe_pkg::CFG_DATA_W;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam int ITEM_TARGET = 1350;
  localparam int CALM_ITEMS  = 150;
  localparam int SETTLE      = 12;
  localparam int HOLD_LEN    = 64;
  localparam int QUIET_LIMIT = 3000;

  typedef struct {
    logic            action;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    bit              wait_drained;
  } stim_item_t;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  action      = 1'b0;
  logic [CH_W-1:0]       pixel_red   = '0;
  logic [CH_W-1:0]       pixel_green = '0;
  logic [CH_W-1:0]       pixel_blue  = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [CH_W-1:0]       out_red;
  logic [CH_W-1:0]       out_green;
  logic [CH_W-1:0]       out_blue;
  logic                  frame_end;

  // filter model state
  logic [PIX_W-1:0] upper_px  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_px [MAX_WIDTH];
  logic [PIX_W-1:0] win_px    [6];
  int unsigned      col_in, row_in, col_out, row_out;
  logic             mode_q;
  logic [11:0]      width_q;
  logic [12:0]      height_q, first_q, stop_q;

  stim_item_t          pixel_queue[$];
  rcbe_pkg::out_item_t expected_pixels[$];
  stim_item_t          cur_item;

  int err_cnt   = 0;
  int n_items   = 0;
  int n_checked = 0;
  int next_hold = 150;
  int hold_cnt  = 0;
  int tx_gap    = 0;
  int rx_gap    = 0;
  int quiet     = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  logic long_hold;

  assign long_hold = (hold_cnt != 0);

  rgb_conv3x3_blur_edge_top i_dut (.*);

  always #5 clk = ~clk;

  function automatic int unsigned dim_clamp(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int chan(input logic [PIX_W-1:0] px, input int ch);
    return int'(px[CH_W*ch +: CH_W]);
  endfunction

  function automatic void restart_frame();
    col_in = 0;
    row_in = 0;
    col_out = 0;
    row_out = 0;
  endfunction

  task automatic filter_pixel(input stim_item_t it);
    int unsigned         w, h, c, p, r, x;
    logic [PIX_W-1:0]    ncol [3];
    logic [CH_W-1:0]     chv [3];
    bit                  drain, emit, border, filt, last;
    int                  sum, s, v, ch, k, i;
    rcbe_pkg::out_item_t res;
    w = dim_clamp(width_q, MAX_WIDTH);
    h = dim_clamp(height_q, MAX_HEIGHT);
    drain = (it.action == ACT_DRAIN);
    if (drain != (row_in >= h)) return;
    c = (col_in >= MAX_WIDTH) ? 0 : col_in;
    ncol[0] = upper_px[c];
    ncol[1] = middle_px[c];
    ncol[2] = drain ? '0 : {it.red, it.green, it.blue};
    if (!drain) begin
      upper_px[c] = ncol[1];
      middle_px[c] = ncol[2];
    end
    p = row_in * w + col_in;
    emit = (p >= w + 1);
    res = '0;
    last = 1'b0;
    if (emit) begin
      r = row_out;
      x = col_out;
      border = (r == 0) || (r + 1 >= h) || (x == 0) || (x + 1 >= w);
      filt = !border && (r >= first_q) && (r < stop_q);
      last = (r + 1 == h) && (x + 1 == w);
      for (k = 0; k < NUM_CH; k++) begin
        ch = NUM_CH - 1 - k;
        v = chan(win_px[1], ch);
        if (filt) begin
          sum = 0;
          for (i = 0; i < 3; i++)
            sum += chan(win_px[3+i], ch) + chan(win_px[i], ch) + chan(ncol[i], ch);
          if (mode_q == rcbe_pkg::MODE_BLUR) begin
            v = sum / 9;
          end else begin
            s = 9 * v - sum;
            v = (s < 0) ? 0 : s / 9;
          end
        end
        chv[k] = CH_W'(v);
      end
      res.red = chv[0];
      res.green = chv[1];
      res.blue = chv[2];
      res.frame_end = last;
    end
    win_px[3] = win_px[0];
    win_px[4] = win_px[1];
    win_px[5] = win_px[2];
    win_px[0] = ncol[0];
    win_px[1] = ncol[1];
    win_px[2] = ncol[2];
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    if (emit) begin
      expected_pixels.push_back(res);
      if (last) begin
        restart_frame();
      end else begin
        col_out++;
        if (col_out >= w) begin
          col_out = 0;
          row_out++;
        end
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      rcbe_pkg::REG_FILTER_MODE: mode_q = val[0];
      rcbe_pkg::REG_IMAGE_WIDTH: begin
        width_q = val[11:0];
        restart_frame();
      end
      rcbe_pkg::REG_IMAGE_HEIGHT: begin
        height_q = val;
        restart_frame();
      end
      rcbe_pkg::REG_FIRST_ROW: first_q = val;
      rcbe_pkg::REG_STOP_ROW: stop_q = val;
      default: ;
    endcase
  endtask

  task automatic settle_idle(input int cycles);
    do @(negedge clk);
    while (pixel_queue.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (cycles) @(negedge clk);
  endtask

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom);
    endcase
  endfunction

  function automatic stim_item_t make_item(input logic act);
    stim_item_t it;
    it.action = act;
    it.red = rand_chan();
    it.green = rand_chan();
    it.blue = rand_chan();
    it.wait_drained = 1'b0;
    return it;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_row(input int unsigned h);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 13'd4096;
      default: return CFG_DATA_W'($urandom_range(0, h + 1));
    endcase
  endfunction

  // one frame in raster order plus its drain items, with stray items mixed in
  task automatic queue_frame(input int unsigned w, input int unsigned h, input int unsigned cut);
    int unsigned n, total, mid;
    stim_item_t  it;
    total = w * h + w + 1;
    mid = (w * h) / 2;
    for (n = 0; n < total; n++) begin
      if (cut != 0 && n == cut) break;
      if ($urandom_range(0, 24) == 0)
        pixel_queue.push_back(make_item(n < w * h ? ACT_DRAIN : ACT_PIXEL));
      it = make_item(n < w * h ? ACT_PIXEL : ACT_DRAIN);
      it.wait_drained = (n == mid) && ($urandom_range(0, 2) == 0);
      pixel_queue.push_back(it);
      n_items++;
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid && !in_stall) filter_pixel(cur_item);
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pixel_queue.size() == 0 ||
                     (pixel_queue[0].wait_drained && expected_pixels.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (tx_idle_en && !long_hold && $urandom_range(0, 9) == 0) begin
          tx_gap <= $urandom_range(0, 13);
          in_valid <= 1'b0;
        end else begin
          cur_item = pixel_queue.pop_front();
          action <= cur_item.action;
          pixel_red <= cur_item.red;
          pixel_green <= cur_item.green;
          pixel_blue <= cur_item.blue;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // output monitor and stall generator
  always @(posedge clk) begin : mon
    rcbe_pkg::out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
      rx_gap <= 0;
      hold_cnt <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_checked <= n_checked + 1;
        if (expected_pixels.size() == 0) begin
          err_cnt++;
          $error("unexpected result: red %0d green %0d blue %0d frame_end %0d",
                 out_red, out_green, out_blue, frame_end);
        end else begin
          want = expected_pixels.pop_front();
          if (out_red !== want.red) begin
            err_cnt++;
            $error("out_red expected %0d actual %0d", want.red, out_red);
          end
          if (out_green !== want.green) begin
            err_cnt++;
            $error("out_green expected %0d actual %0d", want.green, out_green);
          end
          if (out_blue !== want.blue) begin
            err_cnt++;
            $error("out_blue expected %0d actual %0d", want.blue, out_blue);
          end
          if (frame_end !== want.frame_end) begin
            err_cnt++;
            $error("frame_end expected %0d actual %0d", want.frame_end, frame_end);
          end
        end
      end
      if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else if (n_checked >= next_hold && pixel_queue.size() > 40) begin
        // long hold-off so the block fills up and stalls its input
        hold_cnt <= HOLD_LEN;
        next_hold <= next_hold + 400;
        out_stall <= 1'b1;
      end else if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        out_stall <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        rx_gap <= $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned           w, h, nf, f, cut, k;
    int                    phase;
    logic [CFG_DATA_W-1:0] wv, hv;
    stim_item_t            it;
    restart_frame();
    mode_q = rcbe_pkg::MODE_BLUR;
    width_q = 12'd2048;
    height_q = 13'd4096;
    first_q = '0;
    stop_q = 13'd4096;
    for (k = 0; k < 6; k++) win_px[k] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // bright centre on black, laplacian
    write_reg(rcbe_pkg::REG_FILTER_MODE, CFG_DATA_W'(rcbe_pkg::MODE_LAPLACE));
    write_reg(rcbe_pkg::REG_IMAGE_WIDTH, 13'd3);
    write_reg(rcbe_pkg::REG_IMAGE_HEIGHT, 13'd3);
    write_reg(rcbe_pkg::REG_FIRST_ROW, 13'd0);
    write_reg(rcbe_pkg::REG_STOP_ROW, 13'd4096);
    write_reg(REG_UNUSED, '1);
    pixel_queue.push_back(make_item(ACT_DRAIN));
    for (k = 0; k < 9; k++) begin
      it = make_item(ACT_PIXEL);
      {it.red, it.green, it.blue} = (k == 4) ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
      pixel_queue.push_back(it);
    end
    for (k = 0; k < 4; k++) begin
      if (k == 1) pixel_queue.push_back(make_item(ACT_PIXEL));
      pixel_queue.push_back(make_item(ACT_DRAIN));
    end
    settle_idle(SETTLE);

    // dark centre on white, box blur
    write_reg(rcbe_pkg::REG_FILTER_MODE, CFG_DATA_W'(rcbe_pkg::MODE_BLUR));
    for (k = 0; k < 9; k++) begin
      it = make_item(ACT_PIXEL);
      {it.red, it.green, it.blue} = (k == 4) ? {PIX_W{1'b0}} : {PIX_W{1'b1}};
      pixel_queue.push_back(it);
    end
    for (k = 0; k < 4; k++) pixel_queue.push_back(make_item(ACT_DRAIN));
    n_items = 26;

    phase = 0;
    while (n_items < ITEM_TARGET) begin
      settle_idle(SETTLE);
      phase++;
      tx_idle_en = (n_items + CALM_ITEMS < ITEM_TARGET) && ($urandom_range(0, 4) != 0);
      rx_idle_en = (n_items + CALM_ITEMS < ITEM_TARGET) && ($urandom_range(0, 4) != 0);
      if (phase == 3) begin
        // widest and tallest frame, only a few pixels, no results
        write_reg(rcbe_pkg::REG_IMAGE_WIDTH, '1);
        write_reg(rcbe_pkg::REG_IMAGE_HEIGHT, '1);
        for (k = 0; k < 40; k++) pixel_queue.push_back(make_item(ACT_PIXEL));
        n_items += 40;
        continue;
      end
      case ($urandom_range(0, 9))
        0: wv = CFG_DATA_W'($urandom_range(0, 2));
        9: wv = CFG_DATA_W'($urandom_range(13, 40));
        default: wv = CFG_DATA_W'($urandom_range(3, 12));
      endcase
      case ($urandom_range(0, 9))
        0: hv = CFG_DATA_W'($urandom_range(0, 2));
        9: hv = CFG_DATA_W'($urandom_range(11, 16));
        default: hv = CFG_DATA_W'($urandom_range(3, 10));
      endcase
      if (phase == 2) begin
        wv = '0;
        hv = '0;
      end
      // bit 12 lies above the width register
      if ($urandom_range(0, 3) == 0) wv[12] = 1'b1;
      w = dim_clamp(wv[11:0], MAX_WIDTH);
      h = dim_clamp(hv, MAX_HEIGHT);
      write_reg(rcbe_pkg::REG_IMAGE_WIDTH, wv);
      write_reg(rcbe_pkg::REG_IMAGE_HEIGHT, hv);
      if (phase == 1 || $urandom_range(0, 1) == 0)
        write_reg(rcbe_pkg::REG_FILTER_MODE, CFG_DATA_W'($urandom));
      if (phase == 1 || $urandom_range(0, 2) == 0)
        write_reg(rcbe_pkg::REG_FIRST_ROW, pick_row(h));
      if (phase == 1 || $urandom_range(0, 2) == 0)
        write_reg(rcbe_pkg::REG_STOP_ROW, pick_row(h));
      if ($urandom_range(0, 7) == 0)
        write_reg(rcbe_pkg::REG_STOP_ROW + CFG_IDX_W'($urandom_range(1, 3)),
                  CFG_DATA_W'($urandom));
      nf = $urandom_range(1, 3);
      for (f = 0; f < nf; f++) begin
        cut = 0;
        if (f == nf - 1 && $urandom_range(0, 7) == 0) cut = $urandom_range(1, w * h + w);
        queue_frame(w, h, cut);
      end
    end

    settle_idle(SETTLE * 2);
    if (err_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
src/rcbe_pkg.sv
src/rcbe_line_ram.sv
src/rcbe_ctrl.sv
src/rcbe_datapath.sv
src/rcbe_out_fifo.sv
src/rgb_conv3x3_blur_edge_top.sv
tb/testbench.sv
